FILE: hdl/sem_pkg.sv
// Shared types and constants of the Sobel edge magnitude block.
// Depends on nothing; the top level, sem_front, sem_queue and sem_back refer to it by scoped names.
`timescale 1ns / 1ps
package sem_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int CNT_W     = 22;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;
  localparam logic [11:0] ROW_CAP      = 12'd4095;
  localparam logic [20:0] ROOT_SAT     = 21'd65280;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // One classified window on its way from the front to the back.
  typedef struct packed {
    win_t win;
    logic vt;
    logic vb;
    logic vl;
    logic vr;
    logic last;
  } job_t;

endpackage

FILE: hdl/sem_if.sv
// Valid/ready channel interfaces for pixel requests and edge results.
// Depends on nothing.
`timescale 1ns / 1ps
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       flush;
  modport source (output valid, pixel_red, pixel_green, pixel_blue, flush, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, flush, output ready);
endinterface

interface sem_edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_end;
  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

FILE: hdl/sobel_edge_magnitude_rgb.sv
// Top level of the streaming RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_if, sem_ram, sem_front, sem_queue and sem_back.
`timescale 1ns / 1ps
// Pixels enter in raster order on in_chan, one request each, and for every
// colour the block returns round(sqrt(gx*gx + gy*gy)) clamped to 255, with
// pixels outside the frame counted as zero. A result leaves one line plus one
// pixel after its pixel enters, so after the frame the source sends
// frame_width + 1 flush requests to drain the last results; frame_end marks
// the result of the frame's last pixel. After each request the front waits for
// the registered read of the line store RAMs before it takes another, and the
// back works on one result at a time: it squares the six gradients on the
// shared multiplier, then takes the bit-pair square root. A two-entry queue
// between them and an output register let the source and the sink stall
// independently. After reset and after each configuration write the front
// re-derives the output row and column from the emitted count, and takes no
// pixel meanwhile. Register 0 is frame_width (11 bits, 1 to 1024), register 1
// is frame_height (12 bits, 1 to 4095); write them only while the block is idle.
module sobel_edge_magnitude_rgb (
  input  logic        clk,
  input  logic        rst_n,
  sem_pix_if.sink     in_chan,
  sem_edge_if.source  out_chan,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  sem_pkg::job_t q_in;
  sem_pkg::job_t q_out;

  // The front owns the configuration, line stores, window and frame counters.
  sem_front u_front (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  // Classified windows wait here until the back is free.
  sem_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_valid(q_valid), .pop_data(q_out)
  );

  // The back computes gradients and magnitudes and holds the output register.
  sem_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
    .out_chan(out_chan)
  );

  // The front takes no request in the cycle after each request, while the line store read completes.
  a_wait_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready
  ) else $error("pixel request taken during line store read wait");

  // A configuration write starts a recalculation that blocks new pixels.
  a_cfg_blocks_input: assert property (
    @(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_chan.ready
  ) else $error("pixel request possible right after configuration write");

endmodule

FILE: hdl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sem_front.sv
// Front end: configuration registers, line stores, 3x3 window and frame counters.
// Depends on sem_pkg, sem_if and sem_ram.
`timescale 1ns / 1ps
module sem_front (
  input  logic               clk,
  input  logic               rst_n,
  sem_pix_if.sink            in_chan,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output sem_pkg::job_t      q_data
);

  typedef enum logic [1:0] {F_CALC, F_WAIT, F_RUN} fstate_t;

  fstate_t                        state_r;
  logic [10:0]                    w_r;
  logic [11:0]                    h_r;
  logic [sem_pkg::CNT_W-1:0]      total_r;
  logic [sem_pkg::COL_W-1:0]      col_r;
  logic [11:0]                    row_r;
  logic [sem_pkg::CNT_W-1:0]      e_r;
  logic [sem_pkg::CNT_W-1:0]      er_r;
  logic [sem_pkg::COL_W-1:0]      ec_r;
  sem_pkg::win_t                  win_r;
  logic [4:0]                     div_cnt_r;
  logic [10:0]                    div_rem_r;
  logic [sem_pkg::CNT_W-1:0]      div_q_r;

  logic [10:0]                    wc;
  logic [11:0]                    hc;
  logic [sem_pkg::PIX_W-1:0]      px;
  logic [sem_pkg::PIX_W-1:0]      up_rd;
  logic [sem_pkg::PIX_W-1:0]      mid_rd;
  logic [2:0][sem_pkg::PIX_W-1:0] colv;
  sem_pkg::win_t                  win_nxt;
  logic                           acc;
  logic                           emit;
  logic                           last;
  logic [11:0]                    div_sh;
  logic                           div_ge;
  logic [10:0]                    div_rem_nxt;

  always_comb begin
    if (w_r == 11'd0) begin
      wc = 11'd1;
    end else if (w_r > 11'(sem_pkg::MAX_WIDTH)) begin
      wc = 11'(sem_pkg::MAX_WIDTH);
    end else begin
      wc = w_r;
    end
    hc = (h_r == 12'd0) ? 12'd1 : h_r;
  end

  assign in_chan.ready = (state_r == F_RUN) && !q_full;
  assign acc = in_chan.valid && in_chan.ready;
  assign px  = in_chan.flush ? '0 : {in_chan.pixel_blue, in_chan.pixel_green, in_chan.pixel_red};

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_upper (
    .clk(clk), .we(acc), .waddr(col_r), .wdata(mid_rd), .raddr(col_r), .rdata(up_rd)
  );

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_middle (
    .clk(clk), .we(acc), .waddr(col_r), .wdata(px), .raddr(col_r), .rdata(mid_rd)
  );

  always_comb begin
    colv[0] = up_rd;
    colv[1] = mid_rd;
    colv[2] = px;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
      win_nxt[k][2] = colv[k];
    end
  end

  assign emit = (row_r >= 12'd2) || (row_r == 12'd1 && col_r != '0);
  assign last = ({1'b0, e_r} + 23'd1) >= {1'b0, total_r};

  assign q_push         = acc && emit;
  assign q_data.win     = win_nxt;
  assign q_data.vt      = (er_r != '0);
  assign q_data.vb      = ({1'b0, er_r} + 23'd1) < {11'd0, hc};
  assign q_data.vl      = (ec_r != '0);
  assign q_data.vr      = ({1'b0, ec_r} + 11'd1) < wc;
  assign q_data.last    = last;

  // Restoring divider step: emitted count over the clamped width.
  always_comb begin
    div_sh      = {div_rem_r, div_q_r[sem_pkg::CNT_W-1]};
    div_ge      = div_sh >= {1'b0, wc};
    div_rem_nxt = div_ge ? 11'(div_sh - {1'b0, wc}) : div_sh[10:0];
  end

  always_ff @(posedge clk) begin
    total_r <= sem_pkg::CNT_W'({12'd0, wc} * {11'd0, hc});
    if (!rst_n) begin
      state_r   <= F_CALC;
      w_r       <= sem_pkg::WIDTH_RESET;
      h_r       <= sem_pkg::HEIGHT_RESET;
      col_r     <= '0;
      row_r     <= '0;
      e_r       <= '0;
      er_r      <= '0;
      ec_r      <= '0;
      win_r     <= '0;
      div_cnt_r <= '0;
      div_rem_r <= '0;
      div_q_r   <= '0;
    end else begin
      case (state_r)
        F_CALC: begin
          div_rem_r <= div_rem_nxt;
          div_q_r   <= {div_q_r[sem_pkg::CNT_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'(sem_pkg::CNT_W - 1)) begin
            er_r    <= {div_q_r[sem_pkg::CNT_W-2:0], div_ge};
            ec_r    <= div_rem_nxt[sem_pkg::COL_W-1:0];
            state_r <= F_RUN;
          end
        end
        F_WAIT: begin
          state_r <= F_RUN;
        end
        F_RUN: begin
          if (acc) begin
            state_r <= F_WAIT;
            win_r   <= win_nxt;
            if (({1'b0, col_r} + 11'd1) >= wc) begin
              col_r <= '0;
              if (row_r < sem_pkg::ROW_CAP) begin
                row_r <= row_r + 12'd1;
              end
            end else begin
              col_r <= col_r + 1'b1;
            end
            if (emit) begin
              if (last) begin
                col_r <= '0;
                row_r <= '0;
                e_r   <= '0;
                er_r  <= '0;
                ec_r  <= '0;
              end else begin
                e_r <= e_r + 1'b1;
                if (({1'b0, ec_r} + 11'd1) >= wc) begin
                  ec_r <= '0;
                  er_r <= er_r + 1'b1;
                end else begin
                  ec_r <= ec_r + 1'b1;
                end
              end
            end
          end
        end
        default: begin
          state_r <= F_CALC;
        end
      endcase
      if (cfg_we) begin
        case (cfg_index)
          sem_pkg::CFG_FRAME_WIDTH:  w_r <= cfg_data[10:0];
          sem_pkg::CFG_FRAME_HEIGHT: h_r <= cfg_data;
          default: ;
        endcase
        state_r   <= F_CALC;
        div_cnt_r <= '0;
        div_rem_r <= '0;
        div_q_r   <= e_r;
      end
    end
  end

endmodule

FILE: hdl/sem_queue.sv
// Two-entry register queue between the front and the back.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sem_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output sem_pkg::job_t pop_data
);

  sem_pkg::job_t d0_r;
  sem_pkg::job_t d1_r;
  logic [1:0]    cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = d0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (cnt_r == 2'd0) begin
            d0_r <= push_data;
          end else begin
            d1_r <= push_data;
          end
          cnt_r <= cnt_r + 2'd1;
        end
        2'b01: begin
          d0_r  <= d1_r;
          cnt_r <= cnt_r - 2'd1;
        end
        2'b11: begin
          if (cnt_r == 2'd1) begin
            d0_r <= push_data;
          end else begin
            d0_r <= d1_r;
            d1_r <= push_data;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/sem_back.sv
// Back end: Sobel gradients, shared squaring multiplier, digit-by-digit rounded root.
// Depends on sem_pkg and sem_if.
`timescale 1ns / 1ps
module sem_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  sem_pkg::job_t q_data,
  output logic          q_pop,
  sem_edge_if.source    out_chan
);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_ROOT, B_OUT} bstate_t;

  bstate_t          state_r;
  logic [2:0]       cnt_r;
  logic [9:0]       ab_r   [6];
  logic [20:0]      sum_r  [3];
  logic [7:0]       root_r [3];
  logic [9:0]       rem_r  [3];
  logic [2:0]       sat_r;
  logic [7:0]       res_r  [3];
  logic             last_r;
  logic             out_vld_r;
  logic [7:0]       out_r  [3];
  logic             out_end_r;

  logic [7:0]       p    [3][3][3];
  logic [9:0]       sa   [3][4];
  logic [9:0]       ab   [6];
  logic [19:0]      prod;
  logic [11:0]      rsh  [3];
  logic [11:0]      trial[3];
  logic             ge   [3];
  logic [9:0]       rem_n[3];
  logic [7:0]       root_n[3];
  logic [7:0]       fin  [3];
  logic             out_load;

  assign q_pop = (state_r == B_IDLE) && q_valid;

  // The output register takes a new result once it is empty or being drained.
  assign out_load = (state_r == B_OUT) && (!out_vld_r || out_chan.ready);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if ((i == 0 && !q_data.vt) || (i == 2 && !q_data.vb) ||
              (j == 0 && !q_data.vl) || (j == 2 && !q_data.vr)) begin
            p[k][i][j] = '0;
          end else begin
            p[k][i][j] = q_data.win[i][j][8*k +: 8];
          end
        end
      end
      sa[k][0] = {2'b0, p[k][0][2]} + {1'b0, p[k][1][2], 1'b0} + {2'b0, p[k][2][2]};
      sa[k][1] = {2'b0, p[k][0][0]} + {1'b0, p[k][1][0], 1'b0} + {2'b0, p[k][2][0]};
      sa[k][2] = {2'b0, p[k][2][0]} + {1'b0, p[k][2][1], 1'b0} + {2'b0, p[k][2][2]};
      sa[k][3] = {2'b0, p[k][0][0]} + {1'b0, p[k][0][1], 1'b0} + {2'b0, p[k][0][2]};
      ab[2*k]   = (sa[k][0] >= sa[k][1]) ? sa[k][0] - sa[k][1] : sa[k][1] - sa[k][0];
      ab[2*k+1] = (sa[k][2] >= sa[k][3]) ? sa[k][2] - sa[k][3] : sa[k][3] - sa[k][2];
    end
  end

  assign prod = ab_r[cnt_r] * ab_r[cnt_r];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsh[k]    = {rem_r[k], sum_r[k][15:14]};
      trial[k]  = {2'b0, root_r[k], 2'b01};
      ge[k]     = rsh[k] >= trial[k];
      rem_n[k]  = ge[k] ? 10'(rsh[k] - trial[k]) : rsh[k][9:0];
      root_n[k] = {root_r[k][6:0], ge[k]};
      fin[k]    = sat_r[k] ? 8'd255 :
                  (root_n[k] + {7'd0, (rem_n[k] > {2'b0, root_n[k]})});
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.edge_red   = out_r[0];
  assign out_chan.edge_green = out_r[1];
  assign out_chan.edge_blue  = out_r[2];
  assign out_chan.frame_end  = out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            for (int n = 0; n < 6; n++) begin
              ab_r[n] <= ab[n];
            end
            for (int k = 0; k < 3; k++) begin
              sum_r[k] <= '0;
            end
            last_r  <= q_data.last;
            cnt_r   <= '0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          sum_r[cnt_r[2:1]] <= sum_r[cnt_r[2:1]] + {1'b0, prod};
          if (cnt_r == 3'd5) begin
            cnt_r <= '0;
            for (int k = 0; k < 3; k++) begin
              root_r[k] <= '0;
              rem_r[k]  <= '0;
            end
            state_r <= B_ROOT;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        B_ROOT: begin
          for (int k = 0; k < 3; k++) begin
            if (cnt_r == 3'd0) begin
              sat_r[k] <= sum_r[k] > sem_pkg::ROOT_SAT;
            end
            root_r[k] <= root_n[k];
            rem_r[k]  <= rem_n[k];
            sum_r[k]  <= {sum_r[k][18:0], 2'b00};
            res_r[k]  <= fin[k];
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_load) begin
            for (int k = 0; k < 3; k++) begin
              out_r[k] <= res_r[k];
            end
            out_end_r <= last_r;
            state_r   <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule
